// ===== src/tst_pkg.sv =====
// shared constants for the totient sieve table
// status codes, operation codes and data width; no dependencies
`default_nettype none

package tst_pkg;

  localparam int DATA_W = 16;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_BUILT = 2'd1;
  localparam logic [1:0] ST_BEYOND    = 2'd2;

endpackage

`default_nettype wire

// ===== src/totient_sieve_table_unit.sv =====
// totient sieve table: builds phi(0..limit) in one ram and answers reads from it
// depends on tst_pkg, tst_ram and tst_div
// read word: one ram access at accept, result registered in S_RDATA; one word at a time
// build word: (top+1) init writes, a read and check per candidate (2, then odd),
//   and per multiple of each prime a read, a 16-step divide and a write; then result
// reset clears control, limit to 65535, table marked not built; ram is not cleared
`default_nettype none

module totient_sieve_table_unit
  import tst_pkg::*;
#(
  parameter int TABLE_DEPTH = 65536
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration write channel (limit register)
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [DATA_W-1:0] cfg_data,
  // input words
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              operation,
  input  wire logic [DATA_W-1:0] index,
  // result words
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [DATA_W-1:0] totient,
  output logic      [1:0]        status
);

  localparam int          AW      = $clog2(TABLE_DEPTH);
  localparam logic [31:0] MAX_IDX = 32'(TABLE_DEPTH - 1);
  localparam int          CNT_W   = DATA_W + 1;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDATA = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_PRD   = 4'd3;
  localparam logic [3:0] S_PCHK  = 4'd4;
  localparam logic [3:0] S_MRD   = 4'd5;
  localparam logic [3:0] S_MDIV  = 4'd6;
  localparam logic [3:0] S_MWAIT = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]        state;
  logic [DATA_W-1:0] limit;
  logic              table_built;
  logic [DATA_W-1:0] built_limit;
  logic [DATA_W-1:0] top;       // clamped limit of the build in progress
  logic [DATA_W-1:0] n;         // init sweep pointer
  logic [CNT_W-1:0]  p;         // current sieve candidate
  logic [CNT_W-1:0]  m;         // current multiple of p
  logic [DATA_W-1:0] v;         // entry being reduced
  logic [1:0]        rd_status;

  logic              in_accept;
  logic              out_free;
  logic [DATA_W-1:0] top_next;
  logic [CNT_W-1:0]  p_next;
  logic [CNT_W-1:0]  top_ext;

  // ram port
  logic [AW-1:0]     ram_addr;
  logic              ram_we;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [DATA_W-1:0] ram_rdata;

  // divider
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;

  // output register frees up this cycle or is already empty
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == S_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = (state == S_IDLE);

  // clamp the build to the store depth
  assign top_next = (32'(limit) > MAX_IDX) ? DATA_W'(MAX_IDX) : limit;
  // 2, then odd candidates
  assign p_next   = (p == CNT_W'(2)) ? CNT_W'(3) : p + CNT_W'(2);
  assign top_ext  = {1'b0, top};

  assign div_start = (state == S_MDIV);

  // ram access per state; every access is issued and consumed by the sequencer
  // so a read-modify-write of one entry never overlaps another
  always_comb begin
    ram_addr  = AW'(index);
    ram_we    = 1'b0;
    ram_wdata = n;
    ram_re    = 1'b0;
    case (state)
      S_IDLE: begin
        ram_re = in_accept && (operation == OP_READ);
      end
      S_INIT: begin
        ram_addr = AW'(n);
        ram_we   = 1'b1;
      end
      S_PRD: begin
        ram_addr = AW'(p);
        ram_re   = (p <= top_ext);
      end
      S_MRD: begin
        ram_addr = AW'(m);
        ram_re   = (m <= top_ext);
      end
      S_MWAIT: begin
        ram_addr  = AW'(m);
        ram_we    = div_done;
        ram_wdata = v - div_quo;
      end
      default: begin
        ram_addr = AW'(index);
      end
    endcase
  end

  tst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .re    (ram_re),
    .rdata (ram_rdata)
  );

  tst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ram_rdata),
    .divisor  (p[DATA_W-1:0]),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      limit       <= '1;
      table_built <= 1'b0;
      built_limit <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        limit <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= (operation == OP_READ) ? S_RDATA : S_INIT;
          end
        end
        S_RDATA: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_INIT: begin
          if (n == top) begin
            state <= S_PRD;
          end
        end
        S_PRD: begin
          state <= (p <= top_ext) ? S_PCHK : S_DONE;
        end
        S_PCHK: begin
          state <= (ram_rdata == p[DATA_W-1:0]) ? S_MRD : S_PRD;
        end
        S_MRD: begin
          state <= (m <= top_ext) ? S_MDIV : S_PRD;
        end
        S_MDIV: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (div_done) begin
            state <= S_MRD;
          end
        end
        S_DONE: begin
          out_valid   <= 1'b1;
          table_built <= 1'b1;
          built_limit <= top;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          top <= top_next;
          n   <= '0;
          p   <= CNT_W'(2);
          if (!table_built) begin
            rd_status <= ST_NOT_BUILT;
          end else if (index > built_limit) begin
            rd_status <= ST_BEYOND;
          end else begin
            rd_status <= ST_OK;
          end
        end
      end
      S_RDATA: begin
        status  <= rd_status;
        totient <= (rd_status == ST_OK) ? ram_rdata : '0;
      end
      S_INIT: begin
        n <= n + 1'b1;
      end
      S_PCHK: begin
        m <= p;
        if (ram_rdata != p[DATA_W-1:0]) begin
          p <= p_next;
        end
      end
      S_MRD: begin
        if (m > top_ext) begin
          p <= p_next;
        end
      end
      S_MDIV: begin
        v <= ram_rdata;
      end
      S_MWAIT: begin
        if (div_done) begin
          m <= m + p;
        end
      end
      S_DONE: begin
        status  <= ST_OK;
        totient <= '0;
      end
      default: begin
        v <= v;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/tst_ram.sv =====
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module tst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic                     we,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/tst_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// depends on tst_pkg for the data width
`default_nettype none

module tst_div
  import tst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic      [DATA_W-1:0] quotient
);

  localparam int CW = $clog2(DATA_W + 1);

  // partial remainder always stays below the divisor, so DATA_W bits hold it
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dsr;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic [DATA_W:0]   shifted;
  logic              fits;

  assign shifted = {rem, quotient[DATA_W-1]};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DATA_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dsr      <= divisor;
    end else if (busy) begin
      rem      <= fits ? DATA_W'(shifted - {1'b0, dsr}) : shifted[DATA_W-1:0];
      quotient <= {quotient[DATA_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire
